// ----- src/xalu_pkg.sv -----
// xalu_pkg: shared types and operation codes for the x86 integer alu
// no dependencies
`timescale 1ns / 1ps

package xalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_CMP   = 4'd2,
        OP_INC   = 4'd3,
        OP_DEC   = 4'd4,
        OP_ADC   = 4'd5,
        OP_SBB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_IMUL1 = 4'd8,
        OP_IMUL2 = 4'd9,
        OP_IMUL3 = 4'd10,
        OP_DIV   = 4'd11,
        OP_IDIV  = 4'd12
    } op_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // divider request and answer
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

// ----- src/xalu_div.sv -----
// xalu_div: radix-2 restoring divider, 64 by 32 bits, one quotient bit per cycle
// depends on xalu_pkg
`timescale 1ns / 1ps

module xalu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  xalu_pkg::div_req_t req,
    output xalu_pkg::div_rsp_t rsp
);

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    assign trial = {rem_reg[31:0], quo_reg[63]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (!diff[33]) begin
                    rem_reg <= diff[32:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

// ----- src/x86_integer_alu_with_flags.sv -----
// x86_integer_alu_with_flags: x86 add/sub/mul/div alu with cf/zf/sf/of
// depends on xalu_pkg and xalu_div
//
// channel  dir  fields
// s_       in   tdata: op, size_code, dest_value, src_value, imm_value, acc_low_in, acc_high_in
// m_       out  tdata: dest_result, dest_write, acc_low_out, acc_high_out, acc_write,
//                      carry_flag, zero_flag, sign_flag, overflow_flag, divide_error
//
// add/sub: result registered in the prepare step; multiply: product registered
// in ST_MUL (one 32x32 multiplier); divide: shared one-bit-per-cycle divider
// loop, then ST_DFIN packs the result. one transaction at a time; s_tready is low
// while busy and while a result waits on m_tready. reset clears the flags and control.
`timescale 1ns / 1ps

module x86_integer_alu_with_flags (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[3:0], size_code[5:4], dest_value[37:6], src_value[69:38], imm_value[101:70],
    // acc_low_in[133:102], acc_high_in[165:134], zero fill to 168
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_result[31:0], dest_write[32], acc_low_out[64:33], acc_high_out[96:65],
    // acc_write[97], carry_flag[98], zero_flag[99], sign_flag[100],
    // overflow_flag[101], divide_error[102], zero fill to 104
    output logic [103:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_MUL, ST_MULW, ST_DIV, ST_DFIN, ST_OUT
    } state_t;

    state_t state_reg;
    logic [3:0]  op_reg;
    logic [5:0]  n_reg;
    logic [31:0] d_reg, s_reg, imm_reg, eax_reg, edx_reg;
    logic [3:0]  flags_reg;
    logic [63:0] prod_reg;
    logic        nneg_reg, dneg_reg;
    logic [103:0] out_reg;

    xalu_pkg::div_req_t dreq;
    xalu_pkg::div_rsp_t drsp;

    xalu_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // width helpers
    logic [31:0] m, top;
    always_comb begin
        case (n_reg)
            6'd8:    begin m = 32'h0000_00ff; top = 32'h0000_0080; end
            6'd16:   begin m = 32'h0000_ffff; top = 32'h0000_8000; end
            default: begin m = 32'hffff_ffff; top = 32'h8000_0000; end
        endcase
    end

    function automatic logic [31:0] sx(input logic [31:0] v, input logic [5:0] n);
        logic [31:0] r;
        case (n)
            6'd8:    r = {{24{v[7]}}, v[7:0]};
            6'd16:   r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // add/sub path
    logic [32:0] addsub;
    logic [31:0] d_m, s_m, res_m;
    logic        cf_new, of_new, is_sub, cin;
    always_comb begin
        d_m    = d_reg & m;
        s_m    = s_reg & m;
        is_sub = (op_reg == xalu_pkg::OP_SUB) || (op_reg == xalu_pkg::OP_CMP) ||
                 (op_reg == xalu_pkg::OP_SBB) || (op_reg == xalu_pkg::OP_DEC);
        cin    = ((op_reg == xalu_pkg::OP_ADC) || (op_reg == xalu_pkg::OP_SBB))
                 ? flags_reg[0] : 1'b0;
        if ((op_reg == xalu_pkg::OP_INC) || (op_reg == xalu_pkg::OP_DEC))
            s_m = 32'd1 & m;
        if (is_sub)
            addsub = {1'b0, d_m} - {1'b0, s_m} - {32'd0, cin};
        else
            addsub = {1'b0, d_m} + {1'b0, s_m} + {32'd0, cin};
        res_m = addsub[31:0] & m;
        cf_new = ((addsub[31:0] & ~m) != 32'd0) || (n_reg == 6'd32 && addsub[32]);
        if (is_sub)
            of_new = (((d_m ^ s_m) & (d_m ^ res_m) & top) != 32'd0);
        else
            of_new = (((res_m ^ d_m) & (res_m ^ s_m) & top) != 32'd0);
    end

    // multiply operands
    logic        mul_signed;
    logic [31:0] ma, mb, ma_s, mb_s;
    logic signed [32:0] ma_x, mb_x;
    logic signed [65:0] prod_x;
    always_comb begin
        mul_signed = (op_reg != xalu_pkg::OP_MUL);
        case (op_reg)
            xalu_pkg::OP_MUL, xalu_pkg::OP_IMUL1: begin ma = eax_reg; mb = d_reg; end
            xalu_pkg::OP_IMUL2: begin ma = s_reg; mb = d_reg; end
            default: begin ma = s_reg; mb = imm_reg; end
        endcase
        ma_s = sx(ma, n_reg);
        mb_s = sx(mb, n_reg);
        ma_x = mul_signed ? {ma_s[31], ma_s} : {1'b0, ma & m};
        mb_x = mul_signed ? {mb_s[31], mb_s} : {1'b0, mb & m};
        prod_x = ma_x * mb_x;
    end

    // divide operands
    logic [63:0] dvd, dvd_abs;
    logic [31:0] dsr_abs;
    logic        nneg_c, dneg_c;
    always_comb begin
        case (n_reg)
            6'd8:    dvd = {48'd0, eax_reg[15:0]};
            6'd16:   dvd = {32'd0, edx_reg[15:0], eax_reg[15:0]};
            default: dvd = {edx_reg, eax_reg};
        endcase
        case (n_reg)
            6'd8:    nneg_c = dvd[15];
            6'd16:   nneg_c = dvd[31];
            default: nneg_c = dvd[63];
        endcase
        dneg_c = ((d_reg & top) != 32'd0);
        if (op_reg == xalu_pkg::OP_IDIV) begin
            case (n_reg)
                6'd8:    dvd_abs = nneg_c ? {48'd0, 16'd0 - dvd[15:0]} : dvd;
                6'd16:   dvd_abs = nneg_c ? {32'd0, 32'd0 - dvd[31:0]} : dvd;
                default: dvd_abs = nneg_c ? 64'd0 - dvd : dvd;
            endcase
            dsr_abs = dneg_c ? ((32'd0 - d_m) & m) : d_m;
        end else begin
            dvd_abs = dvd;
            dsr_abs = d_m;
        end
    end

    // divide finish
    logic        qneg, derr;
    logic [63:0] qlim;
    logic [31:0] q_out, r_out;
    always_comb begin
        qneg = nneg_reg ^ dneg_reg;
        if (op_reg == xalu_pkg::OP_IDIV)
            qlim = qneg ? {32'd0, top} : {32'd0, top - 32'd1};
        else
            qlim = {32'd0, m};
        derr  = (d_m == 32'd0) || (drsp.quotient > qlim);
        q_out = (op_reg == xalu_pkg::OP_IDIV && qneg)
                ? ((32'd0 - drsp.quotient[31:0]) & m) : drsp.quotient[31:0];
        r_out = (op_reg == xalu_pkg::OP_IDIV && nneg_reg)
                ? ((32'd0 - drsp.remainder) & m) : drsp.remainder;
    end

    function automatic logic [103:0] pack(
        input logic [31:0] dres, input logic dw, input logic [31:0] alo,
        input logic [31:0] ahi, input logic aw, input logic [3:0] f, input logic de);
        return {1'b0, de, f[3], f[2], f[1], f[0], aw, ahi, alo, dw, dres};
    endfunction

    assign dreq.start    = (state_reg == ST_PREP) &&
                           ((op_reg == xalu_pkg::OP_DIV) || (op_reg == xalu_pkg::OP_IDIV));
    assign dreq.dividend = dvd_abs;
    assign dreq.divisor  = dsr_abs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flags_reg <= 4'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tdata[3:0];
                        n_reg   <= (s_tdata[5:4] == xalu_pkg::SIZE_BYTE) ? 6'd8 :
                                   (s_tdata[5:4] == xalu_pkg::SIZE_WORD) ? 6'd16 : 6'd32;
                        d_reg   <= s_tdata[37:6];
                        s_reg   <= s_tdata[69:38];
                        imm_reg <= s_tdata[101:70];
                        eax_reg <= s_tdata[133:102];
                        edx_reg <= s_tdata[165:134];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    case (op_reg)
                        xalu_pkg::OP_ADD, xalu_pkg::OP_SUB, xalu_pkg::OP_CMP,
                        xalu_pkg::OP_ADC, xalu_pkg::OP_SBB: begin
                            flags_reg <= {of_new, (res_m & top) != 32'd0,
                                          res_m == 32'd0, cf_new};
                            out_reg <= pack((op_reg == xalu_pkg::OP_CMP) ? 32'd0 : res_m,
                                            op_reg != xalu_pkg::OP_CMP, eax_reg, edx_reg,
                                            1'b0, {of_new, (res_m & top) != 32'd0,
                                                   res_m == 32'd0, cf_new}, 1'b0);
                            state_reg <= ST_OUT;
                        end
                        xalu_pkg::OP_INC, xalu_pkg::OP_DEC: begin
                            flags_reg <= {of_new, (res_m & top) != 32'd0,
                                          res_m == 32'd0, flags_reg[0]};
                            out_reg <= pack(res_m, 1'b1, eax_reg, edx_reg, 1'b0,
                                            {of_new, (res_m & top) != 32'd0,
                                             res_m == 32'd0, flags_reg[0]}, 1'b0);
                            state_reg <= ST_OUT;
                        end
                        xalu_pkg::OP_MUL, xalu_pkg::OP_IMUL1, xalu_pkg::OP_IMUL2,
                        xalu_pkg::OP_IMUL3: state_reg <= ST_MUL;
                        xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV: begin
                            nneg_reg  <= (op_reg == xalu_pkg::OP_IDIV) && nneg_c;
                            dneg_reg  <= (op_reg == xalu_pkg::OP_IDIV) && dneg_c;
                            state_reg <= ST_DIV;
                        end
                        default: begin
                            out_reg <= pack(32'd0, 1'b0, eax_reg, edx_reg, 1'b0,
                                            flags_reg, 1'b0);
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_MUL: begin
                    prod_reg  <= prod_x[63:0];
                    state_reg <= ST_MULW;
                end
                ST_MULW: begin
                    if (op_reg == xalu_pkg::OP_IMUL2 || op_reg == xalu_pkg::OP_IMUL3)
                        out_reg <= pack(prod_reg[31:0] & m, 1'b1, eax_reg, edx_reg, 1'b0,
                                        flags_reg, 1'b0);
                    else if (n_reg == 6'd8)
                        out_reg <= pack(32'd0, 1'b0, {eax_reg[31:16], prod_reg[15:0]},
                                        edx_reg, 1'b1, flags_reg, 1'b0);
                    else if (n_reg == 6'd16)
                        out_reg <= pack(32'd0, 1'b0, {eax_reg[31:16], prod_reg[15:0]},
                                        {edx_reg[31:16], prod_reg[31:16]}, 1'b1,
                                        flags_reg, 1'b0);
                    else
                        out_reg <= pack(32'd0, 1'b0, prod_reg[31:0], prod_reg[63:32],
                                        1'b1, flags_reg, 1'b0);
                    state_reg <= ST_OUT;
                end
                ST_DIV: begin
                    if (drsp.done) state_reg <= ST_DFIN;
                end
                ST_DFIN: begin
                    if (derr)
                        out_reg <= pack(32'd0, 1'b0, eax_reg, edx_reg, 1'b0,
                                        flags_reg, 1'b1);
                    else if (n_reg == 6'd8)
                        out_reg <= pack(32'd0, 1'b0,
                                        {eax_reg[31:16], r_out[7:0], q_out[7:0]},
                                        edx_reg, 1'b1, flags_reg, 1'b0);
                    else if (n_reg == 6'd16)
                        out_reg <= pack(32'd0, 1'b0, {eax_reg[31:16], q_out[15:0]},
                                        {edx_reg[31:16], r_out[15:0]}, 1'b1,
                                        flags_reg, 1'b0);
                    else
                        out_reg <= pack(32'd0, 1'b0, q_out, r_out, 1'b1, flags_reg, 1'b0);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    // divide error never writes anything
    a_derr_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[102] |-> !m_tdata[97] && !m_tdata[32])
        else $error("divide error with a write");
    // divider only started from the prepare step
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |=> state_reg == ST_DIV)
        else $error("divider start out of sequence");
    // flags only change while an operation is prepared
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) != ST_PREP && $past(aresetn) |-> $stable(flags_reg))
        else $error("flags changed outside prepare step");
    // no new transaction while a result is pending
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

endmodule
